// ===== rtl/core/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and the digit-to-ASCII function of the radix
// digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 32;
    localparam int BASE_W     = 6;
    localparam int CHAR_W     = 7;

    localparam int BASE_MIN = 2;
    localparam int BASE_MAX = 36;

    // divider retires this many quotient bits per cycle
    localparam int STEP_BITS  = 4;
    localparam int DIV_STEPS  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS   = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h41;
    localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [BASE_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
        logic [BASE_W-1:0]   remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else begin
            ch = CHAR_ALPHA + CHAR_W'(d - DEC_DIGITS);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/rdc_div_unit.sv =====
// ----------------------------------------------------------------------------
// rdc_div_unit
// Iterative restoring divider: wide dividend by a 6-bit divisor, STEP_BITS
// quotient bits per cycle. Pulses done with quotient and remainder.
// ----------------------------------------------------------------------------
module rdc_div_unit
    import rdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_BITS-1:0]   r_quo, n_quo;
    logic [BASE_W-1:0]     r_rem, n_rem;
    logic [BASE_W-1:0]     r_div;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [BASE_W:0]       trial;

    // remainder stays below the divisor, so it always fits BASE_W bits
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {n_rem, n_quo[DIV_BITS-1]};
            n_quo = {n_quo[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/core/radix_digit_converter_core.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts a signed integer to ASCII digits in base 2..36, most significant
// digit first, one digit word per strobe.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The magnitude is
// divided by the base once per digit in a shared divider that retires four
// quotient bits a cycle; the digits are then sent from a digit stack, one per
// cycle, with o_last on the final one. A zero value or a bad base gives a
// single word on the next cycle and keeps busy low. Results appear on o_valid
// for exactly one cycle and cannot be held off, so the receiver must take
// every word as it comes.
// ----------------------------------------------------------------------------
module radix_digit_converter_core
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [BASE_W-1:0]     i_base,
    output logic                  o_valid,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_is_negative,
    output logic                  o_bad_base,
    output logic                  o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]            r_state;
    logic [DIG_IDX_W-1:0]  r_cnt;
    logic                  r_neg;
    logic [BASE_W-1:0]     r_base;
    logic [BASE_W-1:0]     r_digs [MAX_DIGITS];

    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_neg;
    logic                  r_out_bad;
    logic                  r_out_last;

    logic                  accept;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_bad;
    logic                  div_more;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign in_neg  = i_value[VALUE_BITS-1];
    assign in_mag  = in_neg ? (~i_value + 1'b1) : i_value;
    assign in_bad  = !(i_base inside {[BASE_MIN:BASE_MAX]});

    // another division follows unless the quotient ran out or the stack is full
    assign div_more = (r_state == S_DIV) && div_rsp.done && (div_rsp.quotient != '0)
                      && (r_cnt != DIG_IDX_W'(MAX_DIGITS - 1));

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = r_base;
        if (accept && !in_bad && (in_mag != '0)) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_BITS'(in_mag);
            div_req.divisor  = i_base;
        end else if (div_more) begin
            div_req.start = 1'b1;
        end
    end

    rdc_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cnt <= '0;
                        if (in_bad || (in_mag == '0)) begin
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (div_more) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_cnt       <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload side: digit stack, sign and output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg      <= in_neg;
            r_base     <= i_base;
            r_out_neg  <= in_neg;
            r_out_bad  <= in_bad;
            r_out_last <= 1'b1;
            r_out_char <= in_bad ? '0 : CHAR_ZERO;
        end
        if ((r_state == S_DIV) && div_rsp.done) begin
            r_digs[r_cnt] <= div_rsp.remainder;
        end
        if (r_state == S_EMIT) begin
            r_out_char <= digit_to_char(r_digs[r_cnt]);
            r_out_neg  <= r_neg;
            r_out_bad  <= 1'b0;
            r_out_last <= (r_cnt == '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_digit_char  = r_out_char;
    assign o_is_negative = r_out_neg;
    assign o_bad_base    = r_out_bad;
    assign o_last        = r_out_last;

endmodule

// ===== tb/radix_digit_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_checker
// Watches the command and digit channels of the radix digit converter,
// predicts the digit words of every accepted command and compares them in
// order, field by field.
// ----------------------------------------------------------------------------
module radix_digit_converter_checker
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [BASE_W-1:0]     i_base,
    input  logic                  i_valid,
    input  logic [CHAR_W-1:0]     i_digit_char,
    input  logic                  i_is_negative,
    input  logic                  i_bad_base,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'h41;
    localparam int                DECIMAL_SPAN = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_negative;
        logic              bad_base;
        logic              last;
    } t_digit_word;

    t_digit_word digit_q[$];
    int          err_cnt = 0;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [BASE_W-1:0] d);
        if (d < DECIMAL_SPAN) begin
            return ASCII_ZERO + CHAR_W'(d);
        end
        return ASCII_LETTER + CHAR_W'(d - DECIMAL_SPAN);
    endfunction

    function automatic void queue_word(input t_digit_word w);
        digit_q = {digit_q, w};
    endfunction

    // queue the digit words of one conversion, most significant first
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
                                           input logic [BASE_W-1:0] b);
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
        logic [BASE_W-1:0]     rems [MAX_DIGITS];
        int                    n;
        t_digit_word           w;
        neg = v[VALUE_BITS-1];
        mag = neg ? (~v + 1'b1) : v;
        n   = 0;
        if (b < BASE_MIN || b > BASE_MAX) begin
            w = {{CHAR_W{1'b0}}, neg, 1'b1, 1'b1};
            queue_word(w);
            return;
        end
        if (mag == 0) begin
            w = {ascii_of('0), neg, 1'b0, 1'b1};
            queue_word(w);
            return;
        end
        while (mag != 0 && n < MAX_DIGITS) begin
            rems[n] = BASE_W'(mag % b);
            mag     = mag / b;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            w = {ascii_of(rems[k]), neg, 1'b0, (k == 0)};
            queue_word(w);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_digit_word got;
        t_digit_word want;
        if (i_rst_n) begin
            // a word leaving now belongs to an earlier command
            if (i_valid) begin
                got = {i_digit_char, i_is_negative, i_bad_base, i_last};
                if (digit_q.size() == 0) begin
                    $error("unexpected digit word: char %h neg %b bad %b last %b",
                           got.digit_char, got.is_negative, got.bad_base, got.last);
                    err_cnt++;
                end else begin
                    want = digit_q.pop_front();
                    if (got.digit_char !== want.digit_char) begin
                        $error("digit_char: expected %h, got %h",
                               want.digit_char, got.digit_char);
                        err_cnt++;
                    end
                    if (got.is_negative !== want.is_negative) begin
                        $error("is_negative: expected %b, got %b",
                               want.is_negative, got.is_negative);
                        err_cnt++;
                    end
                    if (got.bad_base !== want.bad_base) begin
                        $error("bad_base: expected %b, got %b",
                               want.bad_base, got.bad_base);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, got.last);
                        err_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_digits(i_value, i_base);
            end
        end
        o_pending    <= digit_q.size();
        o_fail_count <= err_cnt;
    end

endmodule

// ===== tb/radix_digit_converter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_core_tb
// Drives conversion commands into the radix digit converter: a directed set
// of corner values and bases, then random commands with random gaps. The
// checker beside the block predicts and compares every digit word.
// ----------------------------------------------------------------------------
module radix_digit_converter_core_tb;
    import rdc_pkg::*;

    localparam int RANDOM_WORDS = 200;
    localparam int DRAIN_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 400;   // beyond the longest conversion

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [VALUE_BITS-1:0] i_value;
    logic [BASE_W-1:0]     i_base;
    logic                  o_valid;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_is_negative;
    logic                  o_bad_base;
    logic                  o_last;
    int                    fail_count;
    int                    pending;

    int n_words = 0;
    int n_bad   = 0;
    int n_neg   = 0;
    int n_zero  = 0;

    always #6 i_clk = ~i_clk;

    radix_digit_converter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_base        (i_base),
        .o_valid       (o_valid),
        .o_digit_char  (o_digit_char),
        .o_is_negative (o_is_negative),
        .o_bad_base    (o_bad_base),
        .o_last        (o_last)
    );

    radix_digit_converter_checker u_digit_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_value       (i_value),
        .i_base        (i_base),
        .i_valid       (o_valid),
        .i_digit_char  (o_digit_char),
        .i_is_negative (o_is_negative),
        .i_bad_base    (o_bad_base),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // present one command word and hold it until the block takes it
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic [BASE_W-1:0] b);
        start   <= 1'b1;
        i_value <= v;
        i_base  <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_words++;
        if (b < BASE_MIN || b > BASE_MAX) n_bad++;
        if (v[VALUE_BITS-1]) n_neg++;
        if (v == 0) n_zero++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic idle_gap();
        int gap;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7, 8:    gap = $urandom_range(1, 3);
            default:       gap = $urandom_range(10, 60);
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [VALUE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
                    1: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: v = '1;
                    default: v = 1;
                endcase
            end
            2, 3, 4: begin
                v = $urandom_range(0, 2000);
                if ($urandom_range(0, 1)) v = ~v + 1'b1;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) return BASE_W'($urandom_range(0, BASE_MIN - 1));
            return BASE_W'($urandom_range(BASE_MAX + 1, 63));
        end
        return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        i_base  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero, extremes of value, every digit letter range, bad bases
        send_word(32'd0,          6'd10);
        send_word(32'd0,          6'd2);
        send_word(32'd0,          6'd0);
        send_word(32'h8000_0000,  6'd2);
        send_word(32'h7FFF_FFFF,  6'd2);
        send_word(32'hFFFF_FFFF,  6'd2);
        send_word(32'h8000_0000,  6'd36);
        send_word(32'h7FFF_FFFF,  6'd36);
        send_word(32'h8000_0000,  6'd3);
        send_word(32'd12345,      6'd10);
        send_word(-32'sd255,      6'd16);
        send_word(32'd35,         6'd36);
        send_word(32'd36,         6'd36);
        send_word(32'hFFFF_FFFF,  6'd36);
        send_word(32'd1,          6'd2);
        send_word(32'hDEAD_BEEF,  6'd16);
        send_word(-32'sd7,        6'd1);
        send_word(32'd99,         6'd37);
        send_word(32'h8000_0000,  6'd63);
        send_word(32'd0,          6'd63);
        send_word(32'hFFFF_FFFF,  6'd0);
        send_word(32'd1295,       6'd36);
        send_word(32'h7FFF_FFFF,  6'd10);
        drain_results();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 2) begin
                drain_results();
            end
            idle_gap();
            send_word(pick_value(), pick_base());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Converted %0d commands: %0d negative, %0d zero, %0d with a base out of range.",
                 n_words, n_neg, n_zero, n_bad);
        $display("Bases 0..63 and values from the most negative to the most positive.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rdc_pkg.sv
rtl/core/rdc_div_unit.sv
rtl/core/radix_digit_converter_core.sv
tb/radix_digit_converter_checker.sv
tb/radix_digit_converter_core_tb.sv
